// File: hdl/tmf_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed-mean filter package
// Shared widths, register indexes and the pipeline control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmf_pkg;

  localparam int WINDOW_LEN_DEF = 5;
  localparam int ACC_W          = 17;
  localparam int GYR_W          = 16;
  localparam int NSTG           = 4;
  localparam int CFG_IDX_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ACCEL = 1'b0,
    CFG_FILTER_GYRO  = 1'b1
  } tmf_cfg_idx_e;

  typedef struct packed {
    logic            accept;
    logic            full;
    logic [NSTG-1:0] en;
    logic            filt;
  } tmf_ctrl_t;

endpackage

// File: hdl/six_axis_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// Six-axis moving trimmed-mean filter
// Six lanes, one per axis, each dropping the window min and max and
// averaging the rest; a shared controller steps them in lockstep.
//
//   Channel  Handshake                 Payload
//   input    in_valid_i / in_stall_o   accel_x/y/z_i, gyro_x/y/z_i
//   output   out_valid_o / out_stall_i filtered_o, out_accel_*_o, out_gyro_*_o
//   config   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One word per cycle is accepted while in_stall_o is low; each word passes
// through the window stage, trim stage, reciprocal multiply and
// output register. Reset clears the fill count, running sums and stage
// valids; both filter enables come up set. A stalled output holds its word
// while the earlier stages keep filling any empty slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module six_axis_trimmed_mean_filter #(
  parameter int WINDOW_LEN = tmf_pkg::WINDOW_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic                              cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [tmf_pkg::ACC_W-1:0]  accel_x_i,
  input  logic signed [tmf_pkg::ACC_W-1:0]  accel_y_i,
  input  logic signed [tmf_pkg::ACC_W-1:0]  accel_z_i,
  input  logic signed [tmf_pkg::GYR_W-1:0]  gyro_x_i,
  input  logic signed [tmf_pkg::GYR_W-1:0]  gyro_y_i,
  input  logic signed [tmf_pkg::GYR_W-1:0]  gyro_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              filtered_o,
  output logic signed [tmf_pkg::ACC_W-1:0]  out_accel_x_o,
  output logic signed [tmf_pkg::ACC_W-1:0]  out_accel_y_o,
  output logic signed [tmf_pkg::ACC_W-1:0]  out_accel_z_o,
  output logic signed [tmf_pkg::GYR_W-1:0]  out_gyro_x_o,
  output logic signed [tmf_pkg::GYR_W-1:0]  out_gyro_y_o,
  output logic signed [tmf_pkg::GYR_W-1:0]  out_gyro_z_o
);
  import tmf_pkg::*;

  tmf_ctrl_t ctrl;
  logic      filter_accel_q;
  logic      filter_gyro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_accel_q <= 1'b1;
      filter_gyro_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (tmf_cfg_idx_e'(cfg_idx_i))
        CFG_FILTER_ACCEL: filter_accel_q <= cfg_data_i;
        CFG_FILTER_GYRO:  filter_gyro_q  <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  tmf_ctrl #(
    .WIN_LEN (WINDOW_LEN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .ctrl_o      (ctrl)
  );

  tmf_lane #(.DATA_W(ACC_W), .WIN_LEN(WINDOW_LEN)) u_lane_ax (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl), .enable_i (filter_accel_q),
    .sample_i (accel_x_i), .result_o (out_accel_x_o)
  );

  tmf_lane #(.DATA_W(ACC_W), .WIN_LEN(WINDOW_LEN)) u_lane_ay (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl), .enable_i (filter_accel_q),
    .sample_i (accel_y_i), .result_o (out_accel_y_o)
  );

  tmf_lane #(.DATA_W(ACC_W), .WIN_LEN(WINDOW_LEN)) u_lane_az (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl), .enable_i (filter_accel_q),
    .sample_i (accel_z_i), .result_o (out_accel_z_o)
  );

  tmf_lane #(.DATA_W(GYR_W), .WIN_LEN(WINDOW_LEN)) u_lane_gx (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl), .enable_i (filter_gyro_q),
    .sample_i (gyro_x_i), .result_o (out_gyro_x_o)
  );

  tmf_lane #(.DATA_W(GYR_W), .WIN_LEN(WINDOW_LEN)) u_lane_gy (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl), .enable_i (filter_gyro_q),
    .sample_i (gyro_y_i), .result_o (out_gyro_y_o)
  );

  tmf_lane #(.DATA_W(GYR_W), .WIN_LEN(WINDOW_LEN)) u_lane_gz (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl), .enable_i (filter_gyro_q),
    .sample_i (gyro_z_i), .result_o (out_gyro_z_o)
  );

endmodule

// File: hdl/tmf_ctrl.sv
// ----------------------------------------------------------------------------
// Trimmed-mean filter pipeline control
// Stage valid chain with per-stage load enables, fill counter and the
// filtered flag that travels with each word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmf_ctrl #(
  parameter int WIN_LEN = tmf_pkg::WINDOW_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               filtered_o,
  output tmf_pkg::tmf_ctrl_t ctrl_o
);
  import tmf_pkg::*;

  localparam int HIST_LEN = WIN_LEN - 1;
  localparam int FILL_W   = $clog2(WIN_LEN);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [NSTG-1:0]   vld_q, vld_d;
  logic [NSTG-1:0]   filt_q, filt_d;
  logic [NSTG-1:0]   ready;
  logic              full;
  logic              accept;

  assign full   = (fill_q == FILL_W'(HIST_LEN));
  assign accept = in_valid_i && ready[0];

  always_comb begin
    ready[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ready[k] = !vld_q[k] || ready[k+1];
    end
    vld_d  = vld_q;
    filt_d = filt_q;
    if (ready[0]) begin
      vld_d[0]  = in_valid_i;
      filt_d[0] = full;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ready[k]) begin
        vld_d[k]  = vld_q[k-1];
        filt_d[k] = filt_q[k-1];
      end
    end
    fill_d = fill_q;
    if (accept && !full) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      vld_q  <= '0;
      filt_q <= '0;
    end else begin
      fill_q <= fill_d;
      vld_q  <= vld_d;
      filt_q <= filt_d;
    end
  end

  assign in_stall_o    = !ready[0];
  assign out_valid_o   = vld_q[NSTG-1];
  assign filtered_o    = filt_q[NSTG-1];
  assign ctrl_o.accept = accept;
  assign ctrl_o.full   = full;
  assign ctrl_o.en     = ready;
  assign ctrl_o.filt   = filt_q[NSTG-2];

endmodule

// File: hdl/tmf_lane.sv
// ----------------------------------------------------------------------------
// Trimmed-mean filter lane
// One axis: history shift line, running sum, min/max tree, trim and
// division by a constant through a reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmf_lane #(
  parameter int DATA_W  = tmf_pkg::ACC_W,
  parameter int WIN_LEN = tmf_pkg::WINDOW_LEN_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tmf_pkg::tmf_ctrl_t       ctrl_i,
  input  logic                     enable_i,
  input  logic signed [DATA_W-1:0] sample_i,
  output logic signed [DATA_W-1:0] result_o
);
  import tmf_pkg::*;

  localparam int HIST_LEN = WIN_LEN - 1;
  localparam int LV       = $clog2(WIN_LEN);
  localparam int NP       = 2 ** LV;
  localparam int SUMW     = DATA_W + LV;
  localparam int MAGW     = SUMW - 1;
  localparam int DIV      = WIN_LEN - 2;
  localparam int SH       = MAGW + $clog2(DIV);
  localparam int RW       = SH + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [RW-1:0] RECIP = RECIP_L[RW-1:0];

  logic signed [DATA_W-1:0] hist_q [HIST_LEN];
  logic signed [SUMW-1:0]   hist_sum_q, hist_sum_d;
  logic signed [SUMW-1:0]   sample_ext;
  logic signed [SUMW-1:0]   win_sum;
  logic signed [DATA_W-1:0] mn_t [NP];
  logic signed [DATA_W-1:0] mx_t [NP];

  logic signed [SUMW-1:0]   s1_sum_q;
  logic signed [DATA_W-1:0] s1_min_q, s1_max_q, s1_raw_q;

  logic signed [SUMW-1:0]   trim;
  logic        [SUMW-1:0]   trim_abs;
  logic        [MAGW-1:0]   s2_mag_q;
  logic                     s2_neg_q;
  logic signed [DATA_W-1:0] s2_raw_q;

  logic [MAGW+RW-1:0]       prod;
  logic [DATA_W-1:0]        s3_quo_q;
  logic                     s3_neg_q;
  logic signed [DATA_W-1:0] s3_raw_q;

  logic signed [DATA_W-1:0] mean;
  logic signed [DATA_W-1:0] result_q;

  assign sample_ext = SUMW'(sample_i);
  assign win_sum    = hist_sum_q + sample_ext;

  always_comb begin
    hist_sum_d = hist_sum_q + sample_ext;
    if (ctrl_i.full) begin
      hist_sum_d = hist_sum_q + sample_ext - SUMW'(hist_q[0]);
    end
  end

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      if (i < HIST_LEN) begin
        mn_t[i] = hist_q[i];
        mx_t[i] = hist_q[i];
      end else begin
        mn_t[i] = sample_i;
        mx_t[i] = sample_i;
      end
    end
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < (NP >> (l + 1)); i++) begin
        mn_t[i] = (mn_t[2*i+1] < mn_t[2*i]) ? mn_t[2*i+1] : mn_t[2*i];
        mx_t[i] = (mx_t[2*i+1] > mx_t[2*i]) ? mx_t[2*i+1] : mx_t[2*i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      for (int i = 0; i < HIST_LEN - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[HIST_LEN-1] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_sum_q <= '0;
    end else if (ctrl_i.accept) begin
      hist_sum_q <= hist_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      s1_sum_q <= win_sum;
      s1_min_q <= mn_t[0];
      s1_max_q <= mx_t[0];
      s1_raw_q <= sample_i;
    end
  end

  assign trim     = s1_sum_q - SUMW'(s1_max_q) - SUMW'(s1_min_q);
  assign trim_abs = trim[SUMW-1] ? -trim : trim;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      s2_mag_q <= trim_abs[MAGW-1:0];
      s2_neg_q <= trim[SUMW-1];
      s2_raw_q <= s1_raw_q;
    end
  end

  // The reciprocal is rounded up with enough fraction bits that the
  // quotient is exact for every magnitude that can occur.
  assign prod = (MAGW+RW)'(s2_mag_q) * (MAGW+RW)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      s3_quo_q <= prod[SH +: DATA_W];
      s3_neg_q <= s2_neg_q;
      s3_raw_q <= s2_raw_q;
    end
  end

  assign mean = s3_neg_q ? -signed'(s3_quo_q) : signed'(s3_quo_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      result_q <= (ctrl_i.filt && enable_i) ? mean : s3_raw_q;
    end
  end

  assign result_o = result_q;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Six-axis trimmed-mean filter testbench
// Streams directed and random six-axis samples through the filter under
// every filter-enable setting and under random sender and receiver idling.
// Each word taken is run through a behavioral copy of the moving window,
// and every output word is checked field by field against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tmf_pkg::*;

  localparam int WIN   = WINDOW_LEN_DEF;
  localparam int HIST  = WIN - 1;
  localparam int LIMIT = 200000;
  localparam int AMX   = 65535;
  localparam int AMN   = -65536;
  localparam int GMX   = 32767;
  localparam int GMN   = -32768;

  typedef struct packed {
    logic [2:0][ACC_W-1:0] acc;
    logic [2:0][GYR_W-1:0] gyr;
  } axes_t;

  typedef struct packed {
    logic                  filtered;
    logic [2:0][ACC_W-1:0] acc;
    logic [2:0][GYR_W-1:0] gyr;
  } filter_word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic                     cfg_data_i = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [ACC_W-1:0]  accel_x_i = '0;
  logic signed [ACC_W-1:0]  accel_y_i = '0;
  logic signed [ACC_W-1:0]  accel_z_i = '0;
  logic signed [GYR_W-1:0]  gyro_x_i = '0;
  logic signed [GYR_W-1:0]  gyro_y_i = '0;
  logic signed [GYR_W-1:0]  gyro_z_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     filtered_o;
  logic signed [ACC_W-1:0]  out_accel_x_o;
  logic signed [ACC_W-1:0]  out_accel_y_o;
  logic signed [ACC_W-1:0]  out_accel_z_o;
  logic signed [GYR_W-1:0]  out_gyro_x_o;
  logic signed [GYR_W-1:0]  out_gyro_y_o;
  logic signed [GYR_W-1:0]  out_gyro_z_o;

  axes_t        sample_q[$];
  filter_word_t predicted_words[$];
  axes_t        in_flight;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           mismatches = 0;
  int           cycles = 0;

  logic signed [ACC_W-1:0] acc_hist [3][HIST];
  logic signed [GYR_W-1:0] gyr_hist [3][HIST];
  int                      held = 0;
  bit                      trim_acc_en = 1'b1;
  bit                      trim_gyr_en = 1'b1;

  six_axis_trimmed_mean_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .gyro_x_i     (gyro_x_i),
    .gyro_y_i     (gyro_y_i),
    .gyro_z_i     (gyro_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .filtered_o   (filtered_o),
    .out_accel_x_o(out_accel_x_o),
    .out_accel_y_o(out_accel_y_o),
    .out_accel_z_o(out_accel_z_o),
    .out_gyro_x_o (out_gyro_x_o),
    .out_gyro_y_o (out_gyro_y_o),
    .out_gyro_z_o (out_gyro_z_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint window_mean(input longint vals [WIN]);
    longint total;
    longint hi;
    longint lo;
    total = 0;
    hi = vals[0];
    lo = vals[0];
    foreach (vals[i]) begin
      total += vals[i];
      if (vals[i] > hi) hi = vals[i];
      if (vals[i] < lo) lo = vals[i];
    end
    return (total - hi - lo) / (WIN - 2);
  endfunction

  // Advances the window state by one sample and returns the word it yields.
  function automatic filter_word_t trimmed_filter_step(input axes_t s);
    filter_word_t w;
    longint       acc_win [WIN];
    longint       gyr_win [WIN];
    w.filtered = 1'b0;
    w.acc = s.acc;
    w.gyr = s.gyr;
    if (held < HIST) begin
      for (int a = 0; a < 3; a++) begin
        acc_hist[a][held] = s.acc[a];
        gyr_hist[a][held] = s.gyr[a];
      end
      held++;
    end else begin
      w.filtered = 1'b1;
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < HIST; i++) begin
          acc_win[i] = acc_hist[a][i];
          gyr_win[i] = gyr_hist[a][i];
        end
        acc_win[HIST] = $signed(s.acc[a]);
        gyr_win[HIST] = $signed(s.gyr[a]);
        for (int i = 1; i < HIST; i++) begin
          acc_hist[a][i-1] = acc_hist[a][i];
          gyr_hist[a][i-1] = gyr_hist[a][i];
        end
        acc_hist[a][HIST-1] = s.acc[a];
        gyr_hist[a][HIST-1] = s.gyr[a];
        if (trim_acc_en) w.acc[a] = ACC_W'(window_mean(acc_win));
        if (trim_gyr_en) w.gyr[a] = GYR_W'(window_mean(gyr_win));
      end
    end
    return w;
  endfunction

  function automatic axes_t mk(input int a0, input int a1, input int a2,
                               input int g0, input int g1, input int g2);
    axes_t s;
    s.acc[0] = ACC_W'(a0);
    s.acc[1] = ACC_W'(a1);
    s.acc[2] = ACC_W'(a2);
    s.gyr[0] = GYR_W'(g0);
    s.gyr[1] = GYR_W'(g1);
    s.gyr[2] = GYR_W'(g2);
    return s;
  endfunction

  // Mixes the extremes and clustered small values with uniform noise.
  function automatic logic [ACC_W-1:0] rand_value(input int w);
    int v;
    case ($urandom_range(0, 9))
      0: v = (1 << (w - 1)) - 1;
      1: v = -(1 << (w - 1));
      2, 3, 4: v = int'($urandom_range(0, 16)) - 8;
      default: v = $urandom;
    endcase
    return ACC_W'(v);
  endfunction

  task automatic wait_drained();
    while (sample_q.size() != 0 || predicted_words.size() != 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  task automatic set_filters(input bit acc_on, input bit gyr_on);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FILTER_ACCEL;
    cfg_data_i <= acc_on;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FILTER_GYRO;
    cfg_data_i <= gyr_on;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    trim_acc_en = acc_on;
    trim_gyr_en = gyr_on;
  endtask

  // The sender holds off halfway until every word in flight has come back.
  task automatic queue_random(input int n);
    axes_t s;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) wait_drained();
      for (int a = 0; a < 3; a++) begin
        s.acc[a] = rand_value(ACC_W);
        s.gyr[a] = GYR_W'(rand_value(GYR_W));
      end
      sample_q.push_back(s);
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_words.push_back(trimmed_filter_step(in_flight));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_flight = sample_q.pop_front();
          accel_x_i  <= in_flight.acc[0];
          accel_y_i  <= in_flight.acc[1];
          accel_z_i  <= in_flight.acc[2];
          gyro_x_i   <= in_flight.gyr[0];
          gyro_y_i   <= in_flight.gyr[1];
          gyro_z_i   <= in_flight.gyr[2];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    filter_word_t got;
    filter_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.filtered = filtered_o;
        got.acc[0] = out_accel_x_o;
        got.acc[1] = out_accel_y_o;
        got.acc[2] = out_accel_z_o;
        got.gyr[0] = out_gyro_x_o;
        got.gyr[1] = out_gyro_y_o;
        got.gyr[2] = out_gyro_z_o;
        if (predicted_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = predicted_words.pop_front();
          if (got.filtered !== want.filtered) begin
            $display("%0t: filtered expected %0b actual %0b", $time,
                     want.filtered, got.filtered);
            mismatches++;
          end
          for (int a = 0; a < 3; a++) begin
            if (got.acc[a] !== want.acc[a]) begin
              $display("%0t: accel axis %0d expected %0d actual %0d", $time, a,
                       $signed(want.acc[a]), $signed(got.acc[a]));
              mismatches++;
            end
            if (got.gyr[a] !== want.gyr[a]) begin
              $display("%0t: gyro axis %0d expected %0d actual %0d", $time, a,
                       $signed(want.gyr[a]), $signed(got.gyr[a]));
              mismatches++;
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("six_axis_trimmed_mean_filter test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 47;
    set_filters(1'b1, 1'b1);
    // The fill words pass the extremes through untouched.
    sample_q.push_back(mk(AMX, AMN, 0, GMX, GMN, 0));
    sample_q.push_back(mk(AMN, AMX, -1, GMN, GMX, -1));
    sample_q.push_back(mk(0, -1, 1, 0, -1, 1));
    sample_q.push_back(mk(-1, 0, AMX, -1, 0, GMX));
    sample_q.push_back(mk(AMX, AMX, AMN, GMX, GMX, GMN));
    repeat (4) sample_q.push_back(mk(AMX, AMN, AMX, GMX, GMN, GMX));
    repeat (5) sample_q.push_back(mk(AMN, AMX, AMN, GMN, GMX, GMN));
    // Small negative sums check truncation toward zero.
    sample_q.push_back(mk(-1, -2, 2, -1, -2, 2));
    sample_q.push_back(mk(-2, -1, 1, -2, -1, 1));
    sample_q.push_back(mk(-1, -1, -1, -1, -1, -1));
    sample_q.push_back(mk(1, 0, -2, 1, 0, -2));
    sample_q.push_back(mk(-4, 5, -7, -4, 5, -7));
    wait_drained();

    set_filters(1'b0, 1'b1);
    queue_random(350);

    send_idle_pct = 47;
    recv_idle_pct = 27;
    set_filters(1'b1, 1'b0);
    queue_random(350);
    set_filters(1'b0, 1'b0);
    queue_random(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_filters(1'b1, 1'b1);
    queue_random(350);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && predicted_words.size() == 0) begin
      $display("six_axis_trimmed_mean_filter test passed");
    end else begin
      $display("six_axis_trimmed_mean_filter test failed");
    end
    $finish;
  end

endmodule
